>>> hw/rtl/kp200_pkg.sv
package kp200_pkg;

  localparam int ROUNDS = 18;
  localparam int LANES = 25;

  typedef logic [7:0] lane_t;
  typedef lane_t [LANES-1:0] state_t;

  typedef struct packed {
    logic [63:0] lanes_0_to_7_in;
    logic [63:0] lanes_8_to_15_in;
    logic [63:0] lanes_16_to_23_in;
    logic [7:0]  lane_24_in;
  } in_word_t;

  typedef struct packed {
    logic [63:0] lanes_0_to_7_out;
    logic [63:0] lanes_8_to_15_out;
    logic [63:0] lanes_16_to_23_out;
    logic [7:0]  lane_24_out;
  } out_word_t;

  localparam lane_t ROUND_CONST [ROUNDS] = '{
    8'h01, 8'h82, 8'h8a, 8'h00, 8'h8b, 8'h01, 8'h81, 8'h09, 8'h8a,
    8'h88, 8'h09, 8'h0a, 8'h8b, 8'h8b, 8'h89, 8'h03, 8'h02, 8'h80
  };

  localparam logic [2:0] RHO_OFFSET [LANES] = '{
    3'd0, 3'd1, 3'd6, 3'd4, 3'd3,
    3'd4, 3'd4, 3'd6, 3'd7, 3'd4,
    3'd3, 3'd2, 3'd3, 3'd1, 3'd7,
    3'd1, 3'd5, 3'd7, 3'd5, 3'd0,
    3'd2, 3'd2, 3'd5, 3'd0, 3'd6
  };

  // One full round: theta, rho, pi, chi and iota.
  function automatic state_t round_fn(state_t s, lane_t rc);
    state_t      a;
    state_t      t;
    state_t      o;
    lane_t [4:0] par;
    lane_t [4:0] d;
    lane_t       b;
    logic [15:0] w;
    int          x;
    int          y;
    int          i;
    for (x = 0; x < 5; x++) begin
      par[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
    end
    for (x = 0; x < 5; x++) begin
      d[x] = {par[(x+1)%5][6:0], par[(x+1)%5][7]} ^ par[(x+4)%5];
    end
    for (i = 0; i < LANES; i++) begin
      b = s[i] ^ d[i%5];
      w = {b, b} << RHO_OFFSET[i];
      a[i] = w[15:8];
    end
    for (y = 0; y < 5; y++) begin
      for (x = 0; x < 5; x++) begin
        t[y + 5*((2*x + 3*y) % 5)] = a[x + 5*y];
      end
    end
    for (y = 0; y < 5; y++) begin
      for (x = 0; x < 5; x++) begin
        o[x + 5*y] = t[x + 5*y] ^ (~t[(x+1)%5 + 5*y] & t[(x+2)%5 + 5*y]);
      end
    end
    o[0] = o[0] ^ rc;
    return o;
  endfunction

endpackage

>>> hw/rtl/kp200_round.sv
module kp200_round (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  kp200_pkg::state_t  state_in,
  input  kp200_pkg::lane_t   rc,
  output logic               valid_out,
  output kp200_pkg::state_t  state_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    state_out <= kp200_pkg::round_fn(state_in, rc);
  end

endmodule

>>> hw/rtl/keccak_p200_permutation_unit.sv
// Keccak-f[200] permutation, fully unrolled into one pipeline stage per round.
// A word is taken whenever start is high and busy is low; busy is high only
// while rst is asserted, so a new word may enter on every cycle. Each word
// passes through the 18 registered round stages and comes out with done high
// for a single cycle and the permuted state on result.
// The receiver cannot stall the unit and must take every result as it appears.
module keccak_p200_permutation_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  kp200_pkg::in_word_t  operand,
  output logic                 done,
  output kp200_pkg::out_word_t result
);

  kp200_pkg::state_t             operand_state;
  kp200_pkg::state_t             stage_state [kp200_pkg::ROUNDS+1];
  logic [kp200_pkg::ROUNDS:0]    stage_valid;

  assign busy = rst;
  assign stage_valid[0] = start & ~busy;

  always_comb begin
    int k;
    for (k = 0; k < 8; k++) begin
      operand_state[k]      = operand.lanes_0_to_7_in[8*k +: 8];
      operand_state[8 + k]  = operand.lanes_8_to_15_in[8*k +: 8];
      operand_state[16 + k] = operand.lanes_16_to_23_in[8*k +: 8];
    end
    operand_state[24] = operand.lane_24_in;
  end

  assign stage_state[0] = operand_state;

  for (genvar r = 0; r < kp200_pkg::ROUNDS; r++) begin : g_round
    kp200_round u_round (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (stage_valid[r]),
      .state_in  (stage_state[r]),
      .rc        (kp200_pkg::ROUND_CONST[r]),
      .valid_out (stage_valid[r+1]),
      .state_out (stage_state[r+1])
    );
  end

  assign done = stage_valid[kp200_pkg::ROUNDS];

  always_comb begin
    int k;
    for (k = 0; k < 8; k++) begin
      result.lanes_0_to_7_out[8*k +: 8]   = stage_state[kp200_pkg::ROUNDS][k];
      result.lanes_8_to_15_out[8*k +: 8]  = stage_state[kp200_pkg::ROUNDS][8 + k];
      result.lanes_16_to_23_out[8*k +: 8] = stage_state[kp200_pkg::ROUNDS][16 + k];
    end
    result.lane_24_out = stage_state[kp200_pkg::ROUNDS][24];
  end

  // Every accepted word reaches the output after the full round pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(stage_valid[0], kp200_pkg::ROUNDS) && !$past(rst, kp200_pkg::ROUNDS)
    |-> done)
    else $error("accepted word did not complete after the round pipeline");

  // The last round stage hands its word to the output in the next cycle.
  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    stage_valid[kp200_pkg::ROUNDS-1] |=> done)
    else $error("word lost between the last two round stages");

  // Nothing leaves the pipeline in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result strobe raised right after reset");

endmodule

>>> tb/keccak_p200_permutation_unit_tb.sv
module keccak_p200_permutation_unit_tb;

  localparam int PIPE_DEPTH = 18;
  localparam int STALL_LIMIT = 1000;

  localparam logic [18*8-1:0] IOTA_CONSTS = {
    8'h80, 8'h02, 8'h03, 8'h89, 8'h8b, 8'h8b, 8'h0a, 8'h09, 8'h88,
    8'h8a, 8'h09, 8'h81, 8'h01, 8'h8b, 8'h00, 8'h8a, 8'h82, 8'h01
  };

  localparam logic [25*3-1:0] LANE_ROTATIONS = {
    3'd6, 3'd0, 3'd5, 3'd2, 3'd2,
    3'd0, 3'd5, 3'd7, 3'd5, 3'd1,
    3'd7, 3'd1, 3'd3, 3'd2, 3'd3,
    3'd4, 3'd7, 3'd6, 3'd4, 3'd4,
    3'd3, 3'd4, 3'd6, 3'd1, 3'd0
  };

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  done;
  kp200_pkg::in_word_t   operand;
  kp200_pkg::out_word_t  result;

  kp200_pkg::out_word_t  expected_results[$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         gap_percent = 0;

  keccak_p200_permutation_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] rotate_lane(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic kp200_pkg::out_word_t keccak_f200(kp200_pkg::in_word_t w);
    logic [7:0] s [25];
    logic [7:0] t [25];
    logic [7:0] par [5];
    logic [7:0] mix [5];
    kp200_pkg::out_word_t o;
    int         x;
    int         y;
    int         i;
    int         r;
    for (i = 0; i < 8; i++) begin
      s[i] = w.lanes_0_to_7_in[8*i +: 8];
      s[8+i] = w.lanes_8_to_15_in[8*i +: 8];
      s[16+i] = w.lanes_16_to_23_in[8*i +: 8];
    end
    s[24] = w.lane_24_in;
    for (r = 0; r < 18; r++) begin
      for (x = 0; x < 5; x++) begin
        par[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
      end
      for (x = 0; x < 5; x++) begin
        mix[x] = rotate_lane(par[(x+1)%5], 1) ^ par[(x+4)%5];
      end
      for (i = 0; i < 25; i++) begin
        s[i] = rotate_lane(s[i] ^ mix[i%5], int'(LANE_ROTATIONS[3*i +: 3]));
      end
      for (y = 0; y < 5; y++) begin
        for (x = 0; x < 5; x++) begin
          t[y + 5*((2*x + 3*y) % 5)] = s[x + 5*y];
        end
      end
      for (y = 0; y < 5; y++) begin
        for (x = 0; x < 5; x++) begin
          s[x + 5*y] = t[x + 5*y] ^ (~t[(x+1)%5 + 5*y] & t[(x+2)%5 + 5*y]);
        end
      end
      s[0] = s[0] ^ IOTA_CONSTS[8*r +: 8];
    end
    for (i = 0; i < 8; i++) begin
      o.lanes_0_to_7_out[8*i +: 8] = s[i];
      o.lanes_8_to_15_out[8*i +: 8] = s[8+i];
      o.lanes_16_to_23_out[8*i +: 8] = s[16+i];
    end
    o.lane_24_out = s[24];
    return o;
  endfunction

  function automatic kp200_pkg::in_word_t random_state();
    logic [199:0] bits;
    int           k;
    int           pick;
    pick = $urandom_range(9);
    if (pick == 6) begin
      bits = '0;
      bits[$urandom_range(199)] = 1'b1;
    end else if (pick == 7) begin
      bits = '1;
      bits[$urandom_range(199)] = 1'b0;
    end else begin
      for (k = 0; k < 25; k++) begin
        case (pick >= 8 ? $urandom_range(2) : 2)
          0: bits[8*k +: 8] = 8'h00;
          1: bits[8*k +: 8] = 8'hff;
          default: bits[8*k +: 8] = 8'($urandom_range(255));
        endcase
      end
    end
    return kp200_pkg::in_word_t'(bits);
  endfunction

  task automatic send_word(input kp200_pkg::in_word_t w);
    while ($urandom_range(99) < gap_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operand <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic test_directed_edges();
    kp200_pkg::in_word_t w;
    gap_percent = 9;
    w = '0;
    send_word(w);
    w = '1;
    send_word(w);
    w = '0;
    w.lanes_0_to_7_in = '1;
    send_word(w);
    w = '0;
    w.lanes_8_to_15_in = '1;
    send_word(w);
    w = '0;
    w.lanes_16_to_23_in = '1;
    send_word(w);
    w = '0;
    w.lane_24_in = '1;
    send_word(w);
    w = '0;
    w.lanes_0_to_7_in[0] = 1'b1;
    send_word(w);
    w = '0;
    w.lane_24_in[7] = 1'b1;
    send_word(w);
    w = '0;
    w.lanes_0_to_7_in[63] = 1'b1;
    send_word(w);
    w = kp200_pkg::in_word_t'({25{8'h55}});
    send_word(w);
    w = kp200_pkg::in_word_t'({25{8'haa}});
    send_word(w);
    w = kp200_pkg::in_word_t'({25{8'h01}});
    send_word(w);
    w = kp200_pkg::in_word_t'({25{8'h80}});
    send_word(w);
  endtask

  task automatic test_streaming();
    int n;
    gap_percent = 0;
    for (n = 0; n < 400; n++) begin
      send_word(random_state());
    end
  endtask

  task automatic test_random_gaps();
    int n;
    gap_percent = 9;
    for (n = 0; n < 1200; n++) begin
      send_word(random_state());
    end
  endtask

  always @(posedge clk) begin
    kp200_pkg::out_word_t want;
    if (done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.lanes_0_to_7_out !== want.lanes_0_to_7_out) begin
          $display("%0t: lanes_0_to_7_out expected %h actual %h", $time,
                   want.lanes_0_to_7_out, result.lanes_0_to_7_out);
          error_count++;
        end
        if (result.lanes_8_to_15_out !== want.lanes_8_to_15_out) begin
          $display("%0t: lanes_8_to_15_out expected %h actual %h", $time,
                   want.lanes_8_to_15_out, result.lanes_8_to_15_out);
          error_count++;
        end
        if (result.lanes_16_to_23_out !== want.lanes_16_to_23_out) begin
          $display("%0t: lanes_16_to_23_out expected %h actual %h", $time,
                   want.lanes_16_to_23_out, result.lanes_16_to_23_out);
          error_count++;
        end
        if (result.lane_24_out !== want.lane_24_out) begin
          $display("%0t: lane_24_out expected %h actual %h", $time,
                   want.lane_24_out, result.lane_24_out);
          error_count++;
        end
      end
    end
    if (start && !busy) begin
      expected_results.push_back(keccak_f200(operand));
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("keccak_p200_permutation_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    operand <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_streaming();
    test_random_gaps();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("keccak_p200_permutation_unit_tb: PASS");
    end else begin
      $display("keccak_p200_permutation_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> keccak_p200_permutation_unit.f
hw/rtl/kp200_pkg.sv
hw/rtl/kp200_round.sv
hw/rtl/keccak_p200_permutation_unit.sv
tb/keccak_p200_permutation_unit_tb.sv
